FILE: sv/gyro_bias_calibrator_core_macros.svh
// Assertion macros for the gyro bias calibrator checker.
// Needs no other file; included by the checker only.
`ifndef GYRO_BIAS_CALIBRATOR_CORE_MACROS_SVH
`define GYRO_BIAS_CALIBRATOR_CORE_MACROS_SVH

// same-cycle implication
`define GBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gbc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and reset values of the gyro bias calibrator.
// No dependencies; used by the channel interfaces, the core and its checker.
package gbc_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int NUM_AX          = 3;

  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 36;
  localparam int WIN_W      = 16;
  localparam int MIN_W      = 13;
  localparam int THR_W      = 36;

  localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [STAT_W-1:0] STAT_NONE        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_CALIBRATING = 2'd1;
  localparam logic [STAT_W-1:0] STAT_CALIBRATED  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FAILED      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THR    = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_TICKS_RST = 16'd500;
  localparam logic [MIN_W-1:0] MIN_SAMPLES_RST  = 13'd25;
  localparam logic [THR_W-1:0] NOISE_THR_RST    = 36'd41943;

endpackage

FILE: sv/gbc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: gyro input, corrected output, register writes.
// Depends on gbc_pkg.
interface gbc_in_if;
  import gbc_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              cmd;
  logic signed [SAMPLE_BITS-1:0] gyro_x;
  logic signed [SAMPLE_BITS-1:0] gyro_y;
  logic signed [SAMPLE_BITS-1:0] gyro_z;
  modport source (output valid, cmd, gyro_x, gyro_y, gyro_z, input ready);
  modport sink   (input valid, cmd, gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface gbc_out_if;
  import gbc_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] corr_x;
  logic signed [SAMPLE_BITS-1:0] corr_y;
  logic signed [SAMPLE_BITS-1:0] corr_z;
  logic [STAT_W-1:0]             cal_status;
  modport source (output valid, corr_x, corr_y, corr_z, cal_status, input ready);
  modport sink   (input valid, corr_x, corr_y, corr_z, cal_status, output ready);
endinterface

interface gbc_cfg_if;
  import gbc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/gyro_bias_calibrator_core.sv
`timescale 1ns / 1ps
// Gyro bias calibrator: windowed mean, noise gate, bias subtraction.
// Depends on gbc_pkg and the channel interfaces in gbc_if.sv.
//
//  channel   dir  payload                               beat
//  in_bus    in   cmd, gyro_x/y/z                       one command
//  out_bus   out  corr_x/y/z, cal_status                one corrected sample
//  cfg_bus   in   index, data                           one register write
//
// A tick, restart or unused beat ends at decode, a sample that only passes through at emit;
// a gated sample squares three deviations on one 16x16 multiplier, sums, then checks them.
// A window close runs one restoring divider, one bit a cycle, over three axes,
// each axis sum divided by the sample count, SUM_W = 16 + clog2(MAX_SAMPLES) quotient bits.
// rst_n is synchronous. A waiting output beat only stalls the next one that emits.
module gyro_bias_calibrator_core #(
  parameter int MAX_SAMPLES = gbc_pkg::MAX_SAMPLES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  gbc_in_if.sink           in_bus,
  gbc_out_if.source        out_bus,
  gbc_cfg_if.sink          cfg_bus
);
  import gbc_pkg::*;

  localparam int SB      = SAMPLE_BITS;
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W   = SB + $clog2(MAX_SAMPLES);
  localparam int CMP_W   = (CNT_W > MIN_W) ? CNT_W : MIN_W;
  localparam int PROD_W  = 2 * SB;
  localparam int ACC_W   = PROD_W + 2;
  localparam int STEP_W  = $clog2(SUM_W);
  localparam int AX_W    = $clog2(NUM_AX);
  localparam logic [AX_W-1:0]   AX_LAST  = AX_W'(NUM_AX - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_SAMPLES);
  localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(SUM_W - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SQ_MUL, S_SQ_ACC, S_SQ_CHK,
    S_DIV_INIT, S_DIV_STEP, S_DIV_END, S_EMIT
  } state_t;

  state_t                 state_r;
  logic [CMD_W-1:0]       cmd_r;
  logic signed [SB-1:0]   smp_r   [NUM_AX];
  logic signed [SB-1:0]   bias_r  [NUM_AX];
  logic signed [SUM_W-1:0] sum_r  [NUM_AX];
  logic [CNT_W-1:0]       count_r;
  logic [WIN_W-1:0]       elapsed_r;
  logic                   win_active_r;
  logic                   cont_r;
  logic [STAT_W-1:0]      status_r;
  logic [AX_W-1:0]        ax_r;
  logic [PROD_W-1:0]      prod_r;
  logic [ACC_W-1:0]       acc_r;
  logic [SUM_W-1:0]       div_q_r;
  logic [CNT_W-1:0]       div_rem_r;
  logic [STEP_W-1:0]      div_step_r;
  logic                   div_neg_r;
  logic                   out_valid_r;
  logic signed [SB-1:0]   corr_r  [NUM_AX];
  logic [STAT_W-1:0]      out_status_r;

  logic [WIN_W-1:0]       window_ticks_r;
  logic [MIN_W-1:0]       min_samples_r;
  logic [THR_W-1:0]       noise_thr_r;

  logic signed [SB-1:0]   sel_smp, sel_bias;
  logic signed [SB:0]     dev;
  logic [SB:0]            dev_abs;
  logic [PROD_W-1:0]      sq;
  logic signed [SUM_W-1:0] sel_sum;
  logic [SUM_W-1:0]       sum_mag;
  logic [SUM_W-1:0]       dvd_init;
  logic [CNT_W:0]         rem_sh;
  logic [CNT_W+1:0]       trial;
  logic                   take;
  logic [SB:0]            quot, bias_new;
  logic                   expired, count_ok, count_room, noisy;

  function automatic logic signed [SB-1:0] sat_sub(input logic signed [SB-1:0] a,
                                                    input logic signed [SB-1:0] b);
    logic signed [SB:0] d;
    d = {a[SB-1], a} - {b[SB-1], b};
    if (d[SB] != d[SB-1]) begin
      sat_sub = d[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end else begin
      sat_sub = d[SB-1:0];
    end
  endfunction

  // shared datapath, one axis at a time, selected by ax_r
  assign sel_smp  = smp_r[ax_r];
  assign sel_bias = bias_r[ax_r];
  assign dev      = {sel_smp[SB-1], sel_smp} - {sel_bias[SB-1], sel_bias};
  assign dev_abs  = dev[SB] ? (~dev + 1'b1) : dev;
  // |dev| < 2^SB, so the huge-deviation case of the gate never arises here
  assign sq       = dev_abs[SB-1:0] * dev_abs[SB-1:0];
  assign noisy    = THR_W'(acc_r) > noise_thr_r;

  assign sel_sum  = sum_r[ax_r];
  assign sum_mag  = sel_sum[SUM_W-1] ? (~sel_sum + 1'b1) : sel_sum;
  assign dvd_init = sum_mag + SUM_W'(count_r >> 1);
  assign rem_sh   = {div_rem_r, div_q_r[SUM_W-1]};
  assign trial    = {1'b0, rem_sh} - {2'b00, count_r};
  assign take     = !trial[CNT_W+1];
  assign quot     = div_q_r[SB:0];
  assign bias_new = div_neg_r ? (~quot + 1'b1) : quot;

  assign expired    = elapsed_r > window_ticks_r;
  assign count_ok   = CMP_W'(count_r) > CMP_W'(min_samples_r);
  assign count_room = count_r < CNT_FULL;

  assign in_bus.ready       = (state_r == S_IDLE);
  assign out_bus.valid      = out_valid_r;
  assign out_bus.corr_x     = corr_r[0];
  assign out_bus.corr_y     = corr_r[1];
  assign out_bus.corr_z     = corr_r[2];
  assign out_bus.cal_status = out_status_r;
  assign cfg_bus.ready      = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ticks_r <= WINDOW_TICKS_RST;
      min_samples_r  <= MIN_SAMPLES_RST;
      noise_thr_r    <= NOISE_THR_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        CFG_WINDOW_TICKS: window_ticks_r <= cfg_bus.data[WIN_W-1:0];
        CFG_MIN_SAMPLES:  min_samples_r  <= cfg_bus.data[MIN_W-1:0];
        CFG_NOISE_THR:    noise_thr_r    <= cfg_bus.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      win_active_r <= 1'b0;
      cont_r       <= 1'b0;
      status_r     <= STAT_NONE;
      elapsed_r    <= '0;
      count_r      <= '0;
      for (int i = 0; i < NUM_AX; i++) begin
        sum_r[i]  <= '0;
        bias_r[i] <= '0;
      end
    end else begin
      // in S_EMIT the emit arm owns out_valid_r
      if (out_valid_r && out_bus.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_bus.valid) begin
            cmd_r    <= in_bus.cmd;
            smp_r[0] <= in_bus.gyro_x;
            smp_r[1] <= in_bus.gyro_y;
            smp_r[2] <= in_bus.gyro_z;
            state_r  <= S_DECODE;
          end
        end
        S_DECODE: begin
          state_r <= S_IDLE;
          ax_r    <= '0;
          acc_r   <= '0;
          case (cmd_r)
            CMD_RESTART: begin
              for (int i = 0; i < NUM_AX; i++) begin
                sum_r[i]  <= '0;
                bias_r[i] <= '0;
              end
              count_r      <= '0;
              elapsed_r    <= '0;
              cont_r       <= 1'b0;
              status_r     <= STAT_NONE;
              win_active_r <= 1'b1;
            end
            CMD_TICK: begin
              if (win_active_r && elapsed_r != '1) begin
                elapsed_r <= elapsed_r + 1'b1;
              end
            end
            CMD_SAMPLE: begin
              if (!win_active_r) begin
                state_r <= S_EMIT;
              end else if (expired) begin
                if (count_ok) begin
                  state_r <= S_DIV_INIT;
                end else if (!cont_r) begin
                  status_r     <= STAT_FAILED;
                  win_active_r <= 1'b0;
                end else begin
                  for (int i = 0; i < NUM_AX; i++) sum_r[i] <= '0;
                  count_r   <= '0;
                  elapsed_r <= '0;
                  state_r   <= S_EMIT;
                end
              end else if (cont_r) begin
                state_r <= S_SQ_MUL;
              end else begin
                if (count_room) begin
                  for (int i = 0; i < NUM_AX; i++) begin
                    sum_r[i] <= sum_r[i] + SUM_W'(smp_r[i]);
                  end
                  count_r <= count_r + 1'b1;
                end
                status_r <= STAT_CALIBRATING;
              end
            end
            default: ;
          endcase
        end
        S_SQ_MUL: begin
          prod_r  <= sq;
          state_r <= S_SQ_ACC;
        end
        S_SQ_ACC: begin
          acc_r <= acc_r + ACC_W'(prod_r);
          if (ax_r == AX_LAST) begin
            state_r <= S_SQ_CHK;
          end else begin
            ax_r    <= ax_r + 1'b1;
            state_r <= S_SQ_MUL;
          end
        end
        S_SQ_CHK: begin
          if (!noisy && count_room) begin
            for (int i = 0; i < NUM_AX; i++) begin
              sum_r[i] <= sum_r[i] + SUM_W'(smp_r[i]);
            end
            count_r <= count_r + 1'b1;
          end
          state_r <= S_EMIT;
        end
        S_DIV_INIT: begin
          div_q_r    <= dvd_init;
          div_rem_r  <= '0;
          div_neg_r  <= sel_sum[SUM_W-1];
          div_step_r <= STEP_TOP;
          state_r    <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          div_q_r   <= {div_q_r[SUM_W-2:0], take};
          div_rem_r <= take ? trial[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          if (div_step_r == '0) begin
            state_r <= S_DIV_END;
          end else begin
            div_step_r <= div_step_r - 1'b1;
          end
        end
        S_DIV_END: begin
          bias_r[ax_r] <= bias_new[SB-1:0];
          if (ax_r == AX_LAST) begin
            for (int i = 0; i < NUM_AX; i++) sum_r[i] <= '0;
            count_r   <= '0;
            elapsed_r <= '0;
            status_r  <= STAT_CALIBRATED;
            cont_r    <= 1'b1;
            state_r   <= S_EMIT;
          end else begin
            ax_r    <= ax_r + 1'b1;
            state_r <= S_DIV_INIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_bus.ready) begin
            for (int i = 0; i < NUM_AX; i++) begin
              corr_r[i] <= sat_sub(smp_r[i], bias_r[i]);
            end
            out_status_r <= status_r;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/gbc_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the gyro bias calibrator core, bound to its top level.
// Depends on gbc_pkg and gyro_bias_calibrator_core_macros.svh.
`include "gyro_bias_calibrator_core_macros.svh"

module gbc_port_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [gbc_pkg::CMD_W-1:0]  in_cmd,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [gbc_pkg::STAT_W-1:0] out_cal_status
);
  import gbc_pkg::*;

  `GBC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output beat dropped while stalled")
  `GBC_ASSERT_NXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready, "input taken on consecutive cycles")
  `GBC_ASSERT_NXT(a_no_spurious, clk, rst_n, in_valid && in_ready && in_cmd != CMD_SAMPLE && !out_valid, !out_valid, "result from a non-sample beat")
  `GBC_ASSERT_IMP(a_status_out, clk, rst_n, out_valid, out_cal_status != STAT_CALIBRATING, "result shown during first calibration")

endmodule

bind gyro_bias_calibrator_core gbc_port_checker u_gbc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .in_cmd         (in_bus.cmd),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_cal_status (out_bus.cal_status)
);
